### rtl/crfsb_pkg.sv
// ----------------------------------------------------------------------------
// crfsb_pkg
// shared types, constants and the reply table of the register file block
// ----------------------------------------------------------------------------
package crfsb_pkg;

    localparam int unsigned REG_BYTES_DEF = 256;

    // access kinds
    typedef enum logic [1:0] {
        FUNC_BYTE_RD = 2'd0,
        FUNC_WORD_RD = 2'd1,
        FUNC_BYTE_WR = 2'd2,
        FUNC_WORD_WR = 2'd3
    } t_func;

    // special offsets
    localparam logic [7:0] OFF_BUS     = 8'h2E;
    localparam logic [7:0] OFF_ZERO_LO = 8'h24;
    localparam logic [7:0] OFF_ZERO_HI = 8'h2B;

    // value a word read at the bus offset gives when the serial bit is set
    localparam logic [15:0] BUS_BIT_VAL = 16'h0008;

    // datapath commands from the controller
    typedef struct packed {
        logic capture;   // latch a new transaction
        logic mem_rd;    // read byte store
        logic mem_wr;    // write byte store
        logic addr_nxt;  // address the second byte of a word
        logic wr_hi;     // write data is the high byte
        logic cap_hi;    // take read byte into result bits 15..8
        logic cap_lo;    // take read byte into result bits 7..0
        logic bus_rd;    // result is the serial output bit
        logic bus_step;  // advance the serial bus
        logic load_out;  // move result into the output register
    } t_dp_cmd;

    // datapath status to the controller
    typedef struct packed {
        t_func func;
        logic  bus_hit;
        logic  zero_hit;
    } t_dp_sts;

    // canned reply for a completed serial command
    function automatic logic [15:0] pick_reply(input logic [8:0] cmd);
        logic [15:0] rep;
        unique case (cmd)
            9'h180:  rep = 16'h0024;
            9'h181:  rep = 16'h0004;
            9'h182:  rep = 16'h0071;
            9'h183:  rep = 16'hFF67;
            9'h184:  rep = 16'hFFFF;
            9'h185:  rep = 16'hFFFF;
            default: rep = 16'h0001;
        endcase
        return rep;
    endfunction

endpackage

### rtl/crfsb_ifs.sv
// ----------------------------------------------------------------------------
// crfsb_ifs
// valid/ready channels for bus accesses and their read data
// ----------------------------------------------------------------------------
interface crfsb_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  offset;
    logic [15:0] wdata;

    modport source (output valid, output func, output offset, output wdata, input ready);
    modport sink   (input valid, input func, input offset, input wdata, output ready);
endinterface

interface crfsb_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] rdata;

    modport source (output valid, output rdata, input ready);
    modport sink   (input valid, input rdata, output ready);
endinterface

### rtl/crfsb_ram.sv
// ----------------------------------------------------------------------------
// crfsb_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module crfsb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/crfsb_dp.sv
// ----------------------------------------------------------------------------
// crfsb_dp
// datapath: transaction registers, byte store, result assembly, serial bus
// ----------------------------------------------------------------------------
module crfsb_dp #(
    parameter int unsigned REG_BYTES = crfsb_pkg::REG_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_func,
    input  logic [7:0]        i_offset,
    input  logic [15:0]       i_wdata,
    input  crfsb_pkg::t_dp_cmd i_cmd,
    output crfsb_pkg::t_dp_sts o_sts,
    output logic [15:0]       o_rdata
);
    import crfsb_pkg::*;

    localparam int unsigned AW = $clog2(REG_BYTES);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACTIVE = 2'd1,
        PH_TRAIL  = 2'd2
    } t_phase;

    // transaction registers
    t_func          r_func;
    logic [AW-1:0]  r_off;
    logic [AW-1:0]  r_nxt;
    logic [15:0]    r_wdata;
    logic [15:0]    r_rdata;
    logic [15:0]    r_out_data;

    // byte store and its written flags
    logic [REG_BYTES-1:0] r_vld;
    logic                 r_vld_q;
    logic [AW-1:0]        mem_addr;
    logic [7:0]           mem_wbyte;
    logic [7:0]           mem_q;
    logic [7:0]           rd_byte;

    // serial bus
    t_phase      r_phase;
    logic        r_cmd_active;
    logic [3:0]  r_bit_count;
    logic [8:0]  r_cmd_shift;
    logic [15:0] r_reply_shift;
    logic        r_out_bit;
    logic [8:0]  n_cmd_shift;

    // offset reduction modulo the space size
    logic [9:0]    off_ext;
    logic [9:0]    off_red;
    logic [AW-1:0] off_in;
    logic [AW-1:0] nxt_in;

    always_comb begin
        off_ext = {2'b00, i_offset};
        priority if (off_ext >= 10'(3 * REG_BYTES)) begin
            off_red = off_ext - 10'(3 * REG_BYTES);
        end else if (off_ext >= 10'(2 * REG_BYTES)) begin
            off_red = off_ext - 10'(2 * REG_BYTES);
        end else if (off_ext >= 10'(REG_BYTES)) begin
            off_red = off_ext - 10'(REG_BYTES);
        end else begin
            off_red = off_ext;
        end
        off_in = off_red[AW-1:0];
        nxt_in = (off_in == AW'(REG_BYTES - 1)) ? '0 : off_in + AW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= t_func'(i_func);
            r_off   <= off_in;
            r_nxt   <= nxt_in;
            r_wdata <= i_wdata;
        end
        if (i_cmd.capture) begin
            r_rdata <= '0;
        end else if (i_cmd.bus_rd) begin
            r_rdata <= r_out_bit ? BUS_BIT_VAL : '0;
        end else begin
            if (i_cmd.cap_hi) begin
                r_rdata[15:8] <= rd_byte;
            end
            if (i_cmd.cap_lo) begin
                r_rdata[7:0] <= rd_byte;
            end
        end
        if (i_cmd.load_out) begin
            r_out_data <= r_rdata;
        end
    end

    assign o_sts.func     = r_func;
    assign o_sts.bus_hit  = (8'(r_off) == OFF_BUS);
    assign o_sts.zero_hit = (8'(r_off) >= OFF_ZERO_LO) && (8'(r_off) <= OFF_ZERO_HI);
    assign o_rdata        = r_out_data;

    // byte store access
    assign mem_addr  = i_cmd.addr_nxt ? r_nxt : r_off;
    assign mem_wbyte = i_cmd.wr_hi ? r_wdata[15:8] : r_wdata[7:0];
    assign rd_byte   = r_vld_q ? mem_q : 8'h00;

    crfsb_ram #(
        .WIDTH (8),
        .DEPTH (REG_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_wr),
        .i_waddr (mem_addr),
        .i_wdata (mem_wbyte),
        .i_re    (i_cmd.mem_rd),
        .i_raddr (mem_addr),
        .o_rdata (mem_q)
    );

    // unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_q <= 1'b0;
        end else begin
            if (i_cmd.mem_wr) begin
                r_vld[mem_addr] <= 1'b1;
            end
            if (i_cmd.mem_rd) begin
                r_vld_q <= r_vld[mem_addr];
            end
        end
    end

    // serial bus stepper
    assign n_cmd_shift = {r_cmd_shift[7:0], r_wdata[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_cmd_active  <= 1'b0;
            r_bit_count   <= '0;
            r_cmd_shift   <= '0;
            r_reply_shift <= '0;
            r_out_bit     <= 1'b0;
        end else if (i_cmd.bus_step) begin
            unique case (r_phase)
                PH_IDLE: begin
                    r_phase <= PH_ACTIVE;
                end
                PH_ACTIVE: begin
                    if (r_wdata[0]) begin
                        r_cmd_active <= 1'b1;
                        r_bit_count  <= '0;
                        r_cmd_shift  <= '0;
                    end else if (r_cmd_active) begin
                        r_cmd_shift <= n_cmd_shift;
                        if (r_bit_count == 4'd8) begin
                            r_cmd_active  <= 1'b0;
                            r_reply_shift <= pick_reply(n_cmd_shift);
                            r_bit_count   <= '0;
                        end else begin
                            r_bit_count <= r_bit_count + 4'd1;
                        end
                    end else begin
                        r_out_bit     <= r_reply_shift[15];
                        r_reply_shift <= {r_reply_shift[14:0], 1'b0};
                        r_bit_count   <= r_bit_count + 4'd1;
                    end
                    r_phase <= PH_TRAIL;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    // an open command never counts past its ninth bit
    a_cmd_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd_active |-> (r_bit_count <= 4'd8))
        else $error("command bit count out of range");

    // an active step always leads to the trailing phase
    a_phase_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.bus_step && r_phase == PH_ACTIVE) |=> (r_phase == PH_TRAIL))
        else $error("active phase not followed by trailing phase");

    // the bus only steps on a word write at the bus offset
    a_step_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.bus_step |-> (o_sts.bus_hit && r_func == FUNC_WORD_WR))
        else $error("bus step outside a word write to the bus offset");

endmodule

### rtl/crfsb_ctrl.sv
// ----------------------------------------------------------------------------
// crfsb_ctrl
// controller: sequences byte store accesses and the output handshake
// ----------------------------------------------------------------------------
module crfsb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  crfsb_pkg::t_dp_sts i_sts,
    output crfsb_pkg::t_dp_cmd o_cmd
);
    import crfsb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_B,
        S_RD_W1,
        S_RD_W2,
        S_WR_W2,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   in_acc;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.func)
                    FUNC_BYTE_RD: begin
                        o_cmd.mem_rd = 1'b1;
                        n_state      = S_RD_B;
                    end
                    FUNC_WORD_RD: begin
                        priority if (i_sts.bus_hit) begin
                            o_cmd.bus_rd = 1'b1;
                            n_state      = S_OUT;
                        end else if (i_sts.zero_hit) begin
                            n_state = S_OUT;
                        end else begin
                            o_cmd.mem_rd = 1'b1;
                            n_state      = S_RD_W1;
                        end
                    end
                    FUNC_BYTE_WR: begin
                        o_cmd.mem_wr = 1'b1;
                        n_state      = S_OUT;
                    end
                    FUNC_WORD_WR: begin
                        o_cmd.mem_wr = 1'b1;
                        o_cmd.wr_hi  = 1'b1;
                        n_state      = S_WR_W2;
                    end
                endcase
            end
            S_RD_B: begin
                o_cmd.cap_lo = 1'b1;
                n_state      = S_OUT;
            end
            S_RD_W1: begin
                o_cmd.cap_hi   = 1'b1;
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_nxt = 1'b1;
                n_state        = S_RD_W2;
            end
            S_RD_W2: begin
                o_cmd.cap_lo = 1'b1;
                n_state      = S_OUT;
            end
            S_WR_W2: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.addr_nxt = 1'b1;
                o_cmd.bus_step = i_sts.bus_hit;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> out_free)
        else $error("result loaded over an untaken result");

    // the byte store is written only by write transactions
    a_wr_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mem_wr |-> (i_sts.func == FUNC_BYTE_WR || i_sts.func == FUNC_WORD_WR))
        else $error("store write during a read transaction");

    // every accepted transaction reaches the output stage with no stall on the way
    a_result_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##[2:4] (r_state == S_OUT))
        else $error("result not ready in time");

endmodule

### rtl/cd_register_file_with_serial_bus_core.sv
// ----------------------------------------------------------------------------
// cd_register_file_with_serial_bus_core
// byte/word register space with a bit-banged serial command bus
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+-------------------------------------
//  i_req    | in  | valid / ready   | func[1:0], offset[7:0], wdata[15:0]
//  o_rsp    | out | valid / ready   | rdata[15:0]
//
//  the byte store is a single port ram with registered read, moved one byte a
//  cycle, so word accesses need a second store step that byte accesses do not,
//  and word reads at the bus or zero offsets skip the store entirely
//  i_req.ready is high only while the controller is idle; a result held in
//  the output register does not block the next request until it is ready to
//  be replaced
//  reset is synchronous, active low; written flags make every byte read as
//  zero after reset, with no clearing sweep
//
module cd_register_file_with_serial_bus_core #(
    parameter int unsigned REG_BYTES = crfsb_pkg::REG_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crfsb_req_if.sink   i_req,
    crfsb_rsp_if.source o_rsp
);
    import crfsb_pkg::*;

    // command and status between controller and datapath
    t_dp_cmd cmd;
    t_dp_sts sts;

    // controller owns both handshakes
    crfsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath holds the store, the bus state and the output register
    crfsb_dp #(
        .REG_BYTES (REG_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_func   (i_req.func),
        .i_offset (i_req.offset),
        .i_wdata  (i_req.wdata),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_rdata  (o_rsp.rdata)
    );

endmodule

### verif/cd_register_file_with_serial_bus_core_tb.sv
// ----------------------------------------------------------------------------
// cd_register_file_with_serial_bus_core_tb
// self-checking bench: byte/word accesses and serial bus sequences, with the
// read data of every transaction predicted and compared in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cd_register_file_with_serial_bus_core_tb;

    import crfsb_pkg::*;

    // serial bus phases, stepped by word writes at the bus offset
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACTIVE = 2'd1,
        PH_TRAIL  = 2'd2,
        PH_SPARE  = 2'd3
    } t_bus_phase;

    // known serial commands start here; each has a canned reply in the table
    localparam logic [8:0]  CMD_BASE      = 9'h180;
    localparam int          CMD_KNOWN     = 6;
    localparam logic [15:0] REPLY_TBL [CMD_KNOWN] = '{
        16'h0024, 16'h0004, 16'h0071, 16'hFF67, 16'hFFFF, 16'hFFFF
    };
    localparam logic [15:0] REPLY_DEFAULT = 16'h0001;

    localparam int RANDOM_ACCESSES = 500;
    localparam int STALL_LIMIT     = 1000;   // cycles with no transaction at all
    localparam int HOLD_CYCLES     = 80;     // long receiver hold-off
    localparam int DRAIN_CYCLES    = 16;     // settle time after the last result

    // ------------------------------------------------------------------------
    // scoreboard: mirrors the register space and serial bus, queues the
    // read data each accepted access should produce
    // ------------------------------------------------------------------------
    class regspace_scoreboard;
        logic [7:0]  mem_image [256];
        t_bus_phase  phase;
        logic        cmd_open;
        logic [3:0]  bit_cnt;
        logic [8:0]  cmd_bits;
        logic [15:0] reply_bits;
        logic        out_bit;
        logic [15:0] rdata_due [$];
        int          errors;

        function new();
            foreach (mem_image[i]) mem_image[i] = 8'h00;
            phase      = PH_IDLE;
            cmd_open   = 1'b0;
            bit_cnt    = 4'd0;
            cmd_bits   = 9'd0;
            reply_bits = 16'd0;
            out_bit    = 1'b0;
            errors     = 0;
        endfunction

        // one step of the three-phase serial bus
        function void serial_step(logic [15:0] wd);
            case (phase)
                PH_IDLE: begin
                    phase = PH_ACTIVE;
                end
                PH_ACTIVE: begin
                    if (wd[0]) begin
                        // start bit opens a fresh command
                        cmd_open = 1'b1;
                        bit_cnt  = 4'd0;
                        cmd_bits = 9'd0;
                    end else if (cmd_open) begin
                        cmd_bits = {cmd_bits[7:0], wd[2]};
                        bit_cnt  = bit_cnt + 4'd1;
                        if (bit_cnt == 4'd9) begin
                            // command complete, pick its reply
                            cmd_open = 1'b0;
                            bit_cnt  = 4'd0;
                            if (cmd_bits >= CMD_BASE && cmd_bits < CMD_BASE + CMD_KNOWN)
                                reply_bits = REPLY_TBL[cmd_bits - CMD_BASE];
                            else
                                reply_bits = REPLY_DEFAULT;
                        end
                    end else begin
                        // reply shifts out msb first, zero filled
                        out_bit    = reply_bits[15];
                        reply_bits = {reply_bits[14:0], 1'b0};
                        bit_cnt    = bit_cnt + 4'd1;
                    end
                    phase = PH_TRAIL;
                end
                default: begin
                    phase = PH_IDLE;
                end
            endcase
        endfunction

        // apply an accepted access and queue the read data it returns
        function void note_access(t_func f, logic [7:0] off, logic [15:0] wd);
            logic [7:0]  nxt;
            logic [15:0] rd;
            nxt = off + 8'd1;   // second byte wraps past the end
            rd  = 16'h0000;
            case (f)
                FUNC_BYTE_RD: rd = {8'h00, mem_image[off]};
                FUNC_WORD_RD: begin
                    if (off == OFF_BUS)
                        rd = out_bit ? BUS_BIT_VAL : 16'h0000;
                    else if (off >= OFF_ZERO_LO && off <= OFF_ZERO_HI)
                        rd = 16'h0000;
                    else
                        rd = {mem_image[off], mem_image[nxt]};
                end
                FUNC_BYTE_WR: mem_image[off] = wd[7:0];
                FUNC_WORD_WR: begin
                    mem_image[off] = wd[15:8];
                    mem_image[nxt] = wd[7:0];
                    if (off == OFF_BUS) serial_step(wd);
                end
            endcase
            rdata_due.push_back(rd);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_rdata(logic [15:0] got);
            logic [15:0] want;
            if (rdata_due.size() == 0) begin
                report($sformatf("rdata %h with no access pending", got));
            end else begin
                want = rdata_due.pop_front();
                if (got !== want)
                    report($sformatf("rdata %h, predicted %h", got, want));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    crfsb_req_if req_if ();
    crfsb_rsp_if rsp_if ();

    cd_register_file_with_serial_bus_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    regspace_scoreboard sb = new();

    int unsigned accesses_sent = 0;
    bit          steady        = 1'b0;   // no idling on either side while set
    int          hold_left     = 0;      // receiver hold-off, counted down by the receiver
    int          stall_cycles  = 0;

    // ------------------------------------------------------------------------
    // result side: ready toggles on the falling edge, results taken on the
    // rising edge
    // ------------------------------------------------------------------------
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n !== 1'b1)
                rsp_if.ready <= 1'b0;
            else if (hold_left > 0) begin
                // long hold-off so the block backs up and stalls its input
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else if (steady)
                rsp_if.ready <= 1'b1;
            else
                rsp_if.ready <= ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            sb.check_rdata(rsp_if.rdata);
    end

    // watchdog: any transaction on either channel counts as progress
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (req_if.valid & req_if.ready) === 1'b1 ||
            (rsp_if.valid & rsp_if.ready) === 1'b1)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // offer one access, starting on a falling edge, return on the falling edge
    // after it is taken; valid stays high so back-to-back accesses can stream
    task automatic send_access(input t_func f, input logic [7:0] off,
                               input logic [15:0] wd);
        int unsigned gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 4);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.func   <= f;
        req_if.offset <= off;
        req_if.wdata  <= wd;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        sb.note_access(f, off, wd);
        accesses_sent++;
        @(negedge i_clk);
    endtask

    // sender pause until every queued result has come back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (sb.rdata_due.size() != 0) @(negedge i_clk);
    endtask

    // any access, biased toward the special offsets and the wrap point
    task automatic random_access();
        t_func       f;
        logic [7:0]  off;
        logic [15:0] wd;
        int unsigned pick;
        f    = t_func'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 40)      off = 8'($urandom_range(8'h22, 8'h30));
        else if (pick < 50) off = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else                off = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 10)      wd = 16'h0000;
        else if (pick < 20) wd = 16'hFFFF;
        else                wd = 16'($urandom_range(0, 16'hFFFF));
        send_access(f, off, wd);
    endtask

    // clock the serial bus up to its active phase and apply one data strobe
    task automatic serial_strobe(input logic start, input logic dbit);
        logic [15:0] wd;
        while (sb.phase != PH_ACTIVE)
            send_access(FUNC_WORD_WR, OFF_BUS, 16'($urandom_range(0, 16'hFFFF)));
        wd    = 16'($urandom_range(0, 16'hFFFF));
        wd[0] = start;
        wd[2] = dbit;
        send_access(FUNC_WORD_WR, OFF_BUS, wd);
    endtask

    // start bit plus nine command bits, msb first; sometimes aborted partway
    // and restarted, sometimes with unrelated accesses in between
    task automatic serial_command();
        logic [8:0] cmd;
        int         i;
        if ($urandom_range(0, 99) < 70)
            cmd = CMD_BASE + 9'($urandom_range(0, CMD_KNOWN - 1));
        else
            cmd = 9'($urandom_range(0, 511));
        if ($urandom_range(0, 99) < 20) begin
            serial_strobe(1'b1, 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 8)) serial_strobe(1'b0, 1'($urandom_range(0, 1)));
        end
        serial_strobe(1'b1, 1'($urandom_range(0, 1)));
        for (i = 8; i >= 0; i--) begin
            if ($urandom_range(0, 99) < 15) random_access();
            serial_strobe(1'b0, cmd[i]);
        end
    endtask

    // shift reply bits out and read the serial bit back most of the time;
    // long runs also wrap the bit counter
    task automatic serial_readout();
        repeat ($urandom_range(4, 20)) begin
            serial_strobe(1'b0, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 99) < 60)
                send_access(FUNC_WORD_RD, OFF_BUS, 16'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned target;
        int unsigned pick;
        bit          hold_done;
        bit          pause_done;

        hold_done     = 1'b0;
        pause_done    = 1'b0;
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.func   = FUNC_BYTE_RD;
        req_if.offset = 8'h00;
        req_if.wdata  = 16'h0000;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset contents, wrap of the second byte, zero window
        // edges, byte access inside the window, bus offset without stepping
        send_access(FUNC_WORD_RD, OFF_BUS, 16'h0000);
        send_access(FUNC_BYTE_RD, 8'h00,   16'hFFFF);
        send_access(FUNC_WORD_RD, 8'hFF,   16'h0000);
        send_access(FUNC_BYTE_WR, 8'h00,   16'hFFFF);
        send_access(FUNC_BYTE_WR, 8'hFF,   16'hA55A);
        send_access(FUNC_WORD_WR, 8'hFF,   16'h1234);
        send_access(FUNC_BYTE_RD, 8'hFF,   16'h0000);
        send_access(FUNC_BYTE_RD, 8'h00,   16'h0000);
        send_access(FUNC_WORD_RD, 8'hFF,   16'h0000);
        send_access(FUNC_WORD_WR, 8'h23,   16'hFFFF);
        send_access(FUNC_WORD_WR, OFF_ZERO_HI, 16'hBEEF);
        send_access(FUNC_WORD_WR, 8'h2C,   16'hC0DE);
        send_access(FUNC_WORD_RD, 8'h23,   16'h0000);
        send_access(FUNC_WORD_RD, OFF_ZERO_LO, 16'h0000);
        send_access(FUNC_WORD_RD, OFF_ZERO_HI, 16'h0000);
        send_access(FUNC_WORD_RD, 8'h2C,   16'h0000);
        send_access(FUNC_BYTE_RD, OFF_ZERO_LO, 16'h0000);
        send_access(FUNC_BYTE_RD, OFF_ZERO_HI, 16'h0000);
        send_access(FUNC_WORD_WR, 8'h2D,   16'h5A5A);
        send_access(FUNC_BYTE_WR, OFF_BUS, 16'h00FF);
        send_access(FUNC_BYTE_RD, OFF_BUS, 16'h0000);
        send_access(FUNC_WORD_RD, OFF_BUS, 16'h0000);
        send_access(FUNC_WORD_RD, 8'h2D,   16'h0000);
        send_access(FUNC_WORD_WR, OFF_BUS, 16'h0000);
        send_access(FUNC_WORD_RD, 8'h2F,   16'h0000);

        // random: serial sequences mixed with plain register traffic
        target = accesses_sent + RANDOM_ACCESSES;
        while (accesses_sent < target) begin
            steady = (accesses_sent >= 150 && accesses_sent < 250);
            if (!hold_done && accesses_sent >= 320) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (!pause_done && accesses_sent >= 420) begin
                wait_drained();
                pause_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 20)      serial_command();
            else if (pick < 35) serial_readout();
            else                random_access();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.rdata_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
